// ----- sv/clsr_pkg.sv -----
package clsr_pkg;

   localparam int unsigned TABLE_SIZE_DEF = 32;

   localparam logic [30:0] MOD_ONE      = 31'd2147483563;
   localparam logic [30:0] MOD_TWO      = 31'd2147483399;
   localparam logic [30:0] WRAP_SPAN    = 31'd2147483562;
   localparam logic [30:0] GEN_TWO_INIT = 31'd123456789;
   localparam logic [15:0] MUL_ONE      = 16'd40014;
   localparam logic [15:0] MUL_TWO      = 16'd40692;
   // 2^31 minus each modulus
   localparam logic [7:0]  FOLD_ONE     = 8'd85;
   localparam logic [7:0]  FOLD_TWO     = 8'd249;
   localparam int unsigned WARM_EXTRA   = 8;

   typedef enum logic [2:0] {
      TAG_NONE,
      TAG_G1,
      TAG_G2,
      TAG_SLOT,
      TAG_WARM
   } tag_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WMUL,
      ST_WWAIT,
      ST_WEND,
      ST_D_SLOT,
      ST_D_G1,
      ST_D_G2,
      ST_D_WAIT,
      ST_D_TBL,
      ST_D_OUT
   } step_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_GOTO,
      JMP_LOOP,
      JMP_DISPATCH,
      JMP_EMIT
   } jmp_type;

   typedef struct packed {
      tag_type  src;
      logic     seed_load;
      logic     tbl_rw;
      logic     out_wr;
      jmp_type  jmp;
      step_type target;
   } ctl_type;

   typedef struct packed {
      tag_type     tag;
      logic [30:0] g1;
      logic [30:0] g2;
      logic [30:0] last;
   } opnd_type;

   function automatic ctl_type ucode(input step_type s);
      ctl_type c;
      c = '{src: TAG_NONE, seed_load: 1'b0, tbl_rw: 1'b0, out_wr: 1'b0,
            jmp: JMP_NEXT, target: ST_IDLE};
      case (s)
         ST_IDLE: begin
            c.jmp    = JMP_DISPATCH;
            c.target = ST_D_SLOT;
         end
         ST_LOAD:   c.seed_load = 1'b1;
         ST_WMUL:   c.src = TAG_WARM;
         ST_WWAIT:  c.jmp = JMP_NEXT;
         ST_WEND: begin
            c.jmp    = JMP_LOOP;
            c.target = ST_WMUL;
         end
         ST_D_SLOT: c.src = TAG_SLOT;
         ST_D_G1:   c.src = TAG_G1;
         ST_D_G2:   c.src = TAG_G2;
         ST_D_WAIT: c.jmp = JMP_NEXT;
         ST_D_TBL:  c.tbl_rw = 1'b1;
         ST_D_OUT: begin
            c.out_wr = 1'b1;
            c.jmp    = JMP_EMIT;
            c.target = ST_IDLE;
         end
         default: begin
            c.jmp    = JMP_GOTO;
            c.target = ST_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

// ----- sv/clsr_arith.sv -----
module clsr_arith #(
   parameter int unsigned TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  clsr_pkg::opnd_type            iss,
   output clsr_pkg::tag_type             red_tag,
   output logic [30:0]                   red_value,
   output logic [$clog2(TABLE_SIZE)-1:0] red_slot
);

   localparam int unsigned IW = $clog2(TABLE_SIZE);
   localparam int unsigned QW = $clog2(TABLE_SIZE) + 2;
   localparam logic [30:0] SLOT_DIV =
      31'(1 + 32'(clsr_pkg::WRAP_SPAN) / TABLE_SIZE);
   localparam logic [QW-1:0] SLOT_RECIP = QW'(64'h8000_0000 / 64'(SLOT_DIV));

   logic [30:0]       mul_a;
   logic [15:0]       mul_b;
   logic [46:0]       prod_in;
   logic [46:0]       prod_ff;
   clsr_pkg::tag_type ptag_ff;

   logic [7:0]        fold_c;
   logic [23:0]       fold_hc;
   logic [31:0]       fold_g;
   logic [QW-1:0]     q_est;
   logic [QW+30:0]    qd_full;
   logic [31:0]       fold_in;
   logic [31:0]       fold_ff;
   logic [QW-1:0]     q_ff;
   clsr_pkg::tag_type ftag_ff;

   logic [30:0]       red_mod;
   logic [31:0]       rem;
   logic [QW:0]       qc;

   always_comb begin
      case (iss.tag)
         clsr_pkg::TAG_G1, clsr_pkg::TAG_WARM: begin
            mul_a = iss.g1;
            mul_b = clsr_pkg::MUL_ONE;
         end
         clsr_pkg::TAG_G2: begin
            mul_a = iss.g2;
            mul_b = clsr_pkg::MUL_TWO;
         end
         clsr_pkg::TAG_SLOT: begin
            mul_a = iss.last;
            mul_b = {{(16-QW){1'b0}}, SLOT_RECIP};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = {16'b0, mul_a} * {31'b0, mul_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         ptag_ff <= clsr_pkg::TAG_NONE;
      end else begin
         ptag_ff <= iss.tag;
      end
   end

   // fold the high part back in: x*2^31 = x*(2^31 - m) mod m
   assign fold_c  = (ptag_ff == clsr_pkg::TAG_G2) ? clsr_pkg::FOLD_TWO : clsr_pkg::FOLD_ONE;
   assign fold_hc = {8'b0, prod_ff[46:31]} * {16'b0, fold_c};
   assign fold_g  = {8'b0, fold_hc} + {1'b0, prod_ff[30:0]};
   assign q_est   = prod_ff[31 +: QW];
   assign qd_full = {31'b0, q_est} * {{QW{1'b0}}, SLOT_DIV};
   assign fold_in = (ptag_ff == clsr_pkg::TAG_SLOT) ? qd_full[31:0] : fold_g;

   always_ff @(posedge clock) begin
      fold_ff <= fold_in;
      q_ff    <= q_est;
      if (reset) begin
         ftag_ff <= clsr_pkg::TAG_NONE;
      end else begin
         ftag_ff <= ptag_ff;
      end
   end

   assign red_mod   = (ftag_ff == clsr_pkg::TAG_G2) ? clsr_pkg::MOD_TWO : clsr_pkg::MOD_ONE;
   assign red_value = (fold_ff >= {1'b0, red_mod}) ? 31'(fold_ff - {1'b0, red_mod})
                                                   : fold_ff[30:0];

   // quotient estimate is low by at most one
   assign rem      = {1'b0, iss.last} - fold_ff;
   assign qc       = (rem >= {1'b0, SLOT_DIV}) ? ({1'b0, q_ff} + (QW+1)'(1)) : {1'b0, q_ff};
   assign red_slot = (qc >= (QW+1)'(TABLE_SIZE)) ? IW'(TABLE_SIZE - 1) : qc[IW-1:0];
   assign red_tag  = ftag_ff;

endmodule

// ----- sv/combined_lcg_shuffle_rng.sv -----
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tuser: func; tdata: seed
// rsp      out  rsp_tvalid/rsp_tready  tdata: value
//
// A draw runs six steps of the control program, paced by the multiply/fold/reduce
// pipeline feeding the table; the last step holds while the output register is full,
// and no request is taken until the program is back in IDLE. A reseed loads the seed,
// then one warm-up step per table entry plus WARM_EXTRA, each on its own pipeline pass.
// Reset is synchronous; the table reads as zero until written.
// A finished word waits in the output register while the next item is taken.
module combined_lcg_shuffle_rng #(
   parameter int unsigned TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [30:0] seed, [31] zero
   input  logic [0:0]  req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [30:0] value, [31] zero
);

   localparam int unsigned IW = $clog2(TABLE_SIZE);
   localparam int unsigned CW = $clog2(TABLE_SIZE + clsr_pkg::WARM_EXTRA);

   clsr_pkg::step_type step_ff, step_in;
   clsr_pkg::ctl_type  ctl;
   clsr_pkg::opnd_type iss;
   clsr_pkg::tag_type  red_tag;
   logic [30:0]        red_value;
   logic [IW-1:0]      red_slot;

   logic              req_go;
   logic              emit_go;
   logic [30:0]       seed_ff;
   logic [30:0]       seed_red;
   logic [30:0]       seed_one;
   logic [30:0]       g1_ff;
   logic [30:0]       g2_ff;
   logic [30:0]       last_ff;
   logic [IW-1:0]     slot_ff;
   logic [CW-1:0]     cnt_ff;

   logic [30:0]       tbl_mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] vld_ff;
   logic              mem_we;
   logic [IW-1:0]     mem_wa;
   logic [30:0]       mem_wd;
   logic [30:0]       rd_ff;
   logic              rdv_ff;
   logic [30:0]       rd_eff;
   logic [31:0]       diff;
   logic [31:0]       diff_wrap;
   logic [30:0]       value;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [30:0]       rsp_data_ff;

   assign ctl        = clsr_pkg::ucode(step_ff);
   assign req_tready = (step_ff == clsr_pkg::ST_IDLE);
   assign req_go     = req_tvalid & req_tready;
   assign emit_go    = ctl.out_wr & (~rsp_valid_ff | rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= clsr_pkg::ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      case (ctl.jmp)
         clsr_pkg::JMP_NEXT:     step_in = clsr_pkg::step_type'(step_ff + 4'd1);
         clsr_pkg::JMP_GOTO:     step_in = ctl.target;
         clsr_pkg::JMP_LOOP:     step_in = (cnt_ff != '0) ? ctl.target
                                         : clsr_pkg::step_type'(step_ff + 4'd1);
         clsr_pkg::JMP_DISPATCH: begin
            if (!req_go) begin
               step_in = step_ff;
            end else if (req_tuser[0]) begin
               step_in = clsr_pkg::step_type'(step_ff + 4'd1);
            end else begin
               step_in = ctl.target;
            end
         end
         clsr_pkg::JMP_EMIT:     step_in = emit_go ? ctl.target : step_ff;
         default:                step_in = clsr_pkg::ST_IDLE;
      endcase
   end

   assign iss = '{tag: ctl.src, g1: g1_ff, g2: g2_ff, last: last_ff};

   clsr_arith #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_arith (
      .clock     (clock),
      .reset     (reset),
      .iss       (iss),
      .red_tag   (red_tag),
      .red_value (red_value),
      .red_slot  (red_slot)
   );

   assign seed_red = (seed_ff >= clsr_pkg::MOD_ONE) ? (seed_ff - clsr_pkg::MOD_ONE) : seed_ff;
   assign seed_one = (seed_red == '0) ? 31'd1 : seed_red;

   always_ff @(posedge clock) begin
      if (req_go) begin
         seed_ff <= req_tdata[30:0];
      end
      if (red_tag == clsr_pkg::TAG_SLOT) begin
         slot_ff <= red_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g1_ff   <= 31'd1;
         g2_ff   <= clsr_pkg::GEN_TWO_INIT;
         last_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (ctl.seed_load) begin
            g1_ff  <= seed_one;
            g2_ff  <= seed_one;
            cnt_ff <= CW'(TABLE_SIZE + clsr_pkg::WARM_EXTRA - 1);
         end
         case (red_tag)
            clsr_pkg::TAG_G1: g1_ff <= red_value;
            clsr_pkg::TAG_G2: g2_ff <= red_value;
            clsr_pkg::TAG_WARM: begin
               g1_ff   <= red_value;
               last_ff <= red_value;
               cnt_ff  <= cnt_ff - CW'(1);
            end
            default: ;
         endcase
         if (emit_go) begin
            last_ff <= value;
         end
      end
   end

   always_comb begin
      if (ctl.tbl_rw) begin
         mem_we = 1'b1;
         mem_wa = slot_ff;
         mem_wd = g1_ff;
      end else begin
         mem_we = (red_tag == clsr_pkg::TAG_WARM) && (cnt_ff < CW'(TABLE_SIZE));
         mem_wa = cnt_ff[IW-1:0];
         mem_wd = red_value;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl_mem[mem_wa] <= mem_wd;
      end
      if (ctl.tbl_rw) begin
         rd_ff  <= tbl_mem[slot_ff];
         rdv_ff <= vld_ff[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (mem_we) begin
         vld_ff[mem_wa] <= 1'b1;
      end
   end

   assign rd_eff    = rdv_ff ? rd_ff : '0;
   assign diff      = {1'b0, rd_eff} - {1'b0, g2_ff};
   assign diff_wrap = diff + {1'b0, clsr_pkg::WRAP_SPAN};
   assign value     = (diff[31] || diff == '0) ? diff_wrap[30:0] : diff[30:0];

   assign rsp_valid_in = emit_go | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit_go) begin
         rsp_data_ff <= value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   a_dispatch: assert property (@(posedge clock) disable iff (reset)
      req_go |=> (step_ff == clsr_pkg::ST_LOAD || step_ff == clsr_pkg::ST_D_SLOT))
      else $error("accepted word did not start a program");

   a_warm_align: assert property (@(posedge clock) disable iff (reset)
      (red_tag == clsr_pkg::TAG_WARM) |-> (step_ff == clsr_pkg::ST_WEND))
      else $error("warm-up result out of step with program");

   a_slot_align: assert property (@(posedge clock) disable iff (reset)
      (red_tag == clsr_pkg::TAG_SLOT) |-> (step_ff == clsr_pkg::ST_D_G2))
      else $error("slot result out of step with program");

   a_emit: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> (rsp_tvalid && step_ff == clsr_pkg::ST_IDLE))
      else $error("result word not presented");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[30:0] != '0 && rsp_tdata[30:0] <= clsr_pkg::WRAP_SPAN))
      else $error("result word out of range");

endmodule
